// ----- rtl/websocket_frame_deframer_top_assert.svh -----
// Assertion helpers for the frame deframer.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSDF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wsdf_pkg.sv -----
package wsdf_pkg;

    // Result status codes.
    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_MASK       = 4'd1,
        ST_FRAME_BIG  = 4'd2,
        ST_BAD_CTRL   = 4'd3,
        ST_UNEXP_CONT = 4'd4,
        ST_EXP_CONT   = 4'd5,
        ST_UNK_CTRL   = 4'd6,
        ST_UNK_DATA   = 4'd7,
        ST_MSG_BIG    = 4'd8
    } status_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CLIENT_SIDE  = 2'd0;
    localparam logic [1:0] CFG_LIMIT_ENABLE = 2'd1;
    localparam logic [1:0] CFG_MAX_MESSAGE  = 2'd2;

    // Opcodes and header constants.
    localparam logic [3:0] OP_CONT       = 4'd0;
    localparam logic [3:0] OP_FIRST_BAD  = 4'd3;
    localparam logic [3:0] OP_CLOSE      = 4'd8;
    localparam logic [3:0] OP_LAST_CTRL  = 4'd10;
    localparam logic [6:0] LEN_EXT16     = 7'd126;
    localparam logic [6:0] LEN_EXT64     = 7'd127;
    localparam logic [63:0] CTRL_MAX_LEN = 64'd125;

    // One result beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic [3:0] frame_opcode;
        logic       frame_last;
        logic       message_last;
        status_t    status;
        logic       halted;
    } result_t;

endpackage

// ----- rtl/websocket_frame_deframer_top.sv -----
// WebSocket receive deframer: takes one received byte per beat, parses the frame header
// (FIN, opcode, 7/16/64-bit length, optional mask key), checks it, and streams the
// unmasked payload out one byte per beat, tagged with the opcode and frame/message end
// marks. Bytes can follow back to back at one per clock cycle; only a result that waits
// on m_tready holds the input back. Each byte waits in the input register while the
// parse logic works on it, and its result is registered in the result register that
// drives the result bus. Header bytes give no result except the one that completes a
// header when the checks fail or the payload is empty. After an error or a finished
// close frame the block keeps accepting bytes but drops them until reset.
module websocket_frame_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [8] message_last, [12:9] status,
                                   // [13] halted, [15:14] zero
    output logic [4:0]  m_tuser,   // [0] byte_valid, [4:1] frame_opcode
    output logic        m_tlast,   // frame_last
    // Configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Configuration registers.
    logic        client_side_reg;
    logic        limit_enable_reg;
    logic [31:0] max_message_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            client_side_reg  <= 1'b0;
            limit_enable_reg <= 1'b0;
            max_message_reg  <= '0;
        end else if (cfg_we) begin
            if (cfg_index == wsdf_pkg::CFG_CLIENT_SIDE) client_side_reg <= cfg_data[0];
            if (cfg_index == wsdf_pkg::CFG_LIMIT_ENABLE) limit_enable_reg <= cfg_data[0];
            if (cfg_index == wsdf_pkg::CFG_MAX_MESSAGE) max_message_reg <= cfg_data;
        end
    end

    // Input register stage.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       out_ready;
    logic       proc;

    assign out_ready = !out_valid_reg || m_tready;
    assign proc      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Parser state.
    logic [3:0]  hdr_pos_reg, hdr_pos_next;
    logic        fin_reg, fin_next;
    logic [3:0]  cur_op_reg, cur_op_next;
    logic        mask_flag_reg, mask_flag_next;
    logic [6:0]  short_len_reg, short_len_next;
    logic [63:0] pay_len_reg, pay_len_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [63:0] remain_reg, remain_next;
    logic [1:0]  idx_reg, idx_next;
    logic        in_payload_reg, in_payload_next;
    logic        msg_active_reg, msg_active_next;
    logic [3:0]  msg_op_reg, msg_op_next;
    logic [63:0] msg_size_reg, msg_size_next;
    logic        stopped_reg, stopped_next;

    wsdf_pkg::result_t res;
    logic              emit;
    logic              finish;

    // Header decode helpers.
    logic [6:0]  slen_eff;
    logic        mflag_eff;
    logic [3:0]  ext_len;
    logic [3:0]  pos_inc;
    logic [3:0]  hdr_total;
    logic [63:0] plen_eff;
    logic [63:0] base_size;
    logic [63:0] sum_size;
    logic [63:0] max_ext;
    logic        is_ctrl;
    logic        is_data_unk;
    wsdf_pkg::status_t chk;
    logic [7:0]  key_byte;

    always_comb begin
        hdr_pos_next    = hdr_pos_reg;
        fin_next        = fin_reg;
        cur_op_next     = cur_op_reg;
        mask_flag_next  = mask_flag_reg;
        short_len_next  = short_len_reg;
        pay_len_next    = pay_len_reg;
        mask_key_next   = mask_key_reg;
        remain_next     = remain_reg;
        idx_next        = idx_reg;
        in_payload_next = in_payload_reg;
        msg_active_next = msg_active_reg;
        msg_op_next     = msg_op_reg;
        msg_size_next   = msg_size_reg;
        stopped_next    = stopped_reg;

        res         = '0;
        res.status  = wsdf_pkg::ST_OK;
        emit        = 1'b0;
        finish      = 1'b0;

        is_ctrl     = cur_op_reg >= wsdf_pkg::OP_CLOSE;
        is_data_unk = cur_op_reg >= wsdf_pkg::OP_FIRST_BAD;
        max_ext     = {32'd0, max_message_reg};

        // Header field values as they stand after this byte.
        if (hdr_pos_reg == 4'd1) begin
            slen_eff  = in_byte_reg[6:0];
            mflag_eff = in_byte_reg[7];
        end else begin
            slen_eff  = short_len_reg;
            mflag_eff = mask_flag_reg;
        end
        if (slen_eff == wsdf_pkg::LEN_EXT16) begin
            ext_len = 4'd2;
        end else if (slen_eff == wsdf_pkg::LEN_EXT64) begin
            ext_len = 4'd8;
        end else begin
            ext_len = 4'd0;
        end
        pos_inc   = hdr_pos_reg + 4'd1;
        hdr_total = 4'd2 + ext_len + (mflag_eff ? 4'd4 : 4'd0);

        if (hdr_pos_reg == 4'd1) begin
            plen_eff = (ext_len == 4'd0) ? {57'd0, in_byte_reg[6:0]} : 64'd0;
        end else if (hdr_pos_reg < 4'd2 + ext_len) begin
            plen_eff = {pay_len_reg[55:0], in_byte_reg};
        end else begin
            plen_eff = pay_len_reg;
        end

        // Message size after this frame; wraps modulo 2^64.
        base_size = (cur_op_reg == wsdf_pkg::OP_CONT) ? msg_size_reg : 64'd0;
        sum_size  = base_size + plen_eff;

        // Header checks, first failure wins.
        if (client_side_reg ? mflag_eff : !mflag_eff) begin
            chk = wsdf_pkg::ST_MASK;
        end else if (limit_enable_reg && plen_eff > max_ext) begin
            chk = wsdf_pkg::ST_FRAME_BIG;
        end else if (is_ctrl && (!fin_reg || plen_eff > wsdf_pkg::CTRL_MAX_LEN)) begin
            chk = wsdf_pkg::ST_BAD_CTRL;
        end else if (is_ctrl && cur_op_reg > wsdf_pkg::OP_LAST_CTRL) begin
            chk = wsdf_pkg::ST_UNK_CTRL;
        end else if (is_ctrl) begin
            chk = wsdf_pkg::ST_OK;
        end else if (cur_op_reg == wsdf_pkg::OP_CONT && !msg_active_reg) begin
            chk = wsdf_pkg::ST_UNEXP_CONT;
        end else if (cur_op_reg != wsdf_pkg::OP_CONT && msg_active_reg) begin
            chk = wsdf_pkg::ST_EXP_CONT;
        end else if (is_data_unk) begin
            chk = wsdf_pkg::ST_UNK_DATA;
        end else if (limit_enable_reg && sum_size > max_ext) begin
            chk = wsdf_pkg::ST_MSG_BIG;
        end else begin
            chk = wsdf_pkg::ST_OK;
        end

        // Mask key byte for this payload position, first key byte first.
        case (idx_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase

        if (proc && !stopped_reg) begin
            if (in_payload_reg) begin
                // Payload byte: unmask and count down.
                emit             = 1'b1;
                res.data_byte    = in_byte_reg ^ key_byte;
                res.byte_valid   = 1'b1;
                res.frame_opcode = is_ctrl ? cur_op_reg : msg_op_reg;
                idx_next         = idx_reg + 2'd1;
                remain_next      = remain_reg - 64'd1;
                finish           = (remain_reg == 64'd1);
            end else if (hdr_pos_reg == 4'd0) begin
                // First header byte: FIN and opcode.
                fin_next      = in_byte_reg[7];
                cur_op_next   = in_byte_reg[3:0];
                mask_key_next = '0;
                pay_len_next  = '0;
                hdr_pos_next  = 4'd1;
            end else begin
                // Length, extended length and mask key bytes.
                mask_flag_next = mflag_eff;
                short_len_next = slen_eff;
                pay_len_next   = plen_eff;
                if (hdr_pos_reg >= 4'd2 + ext_len) begin
                    mask_key_next = {mask_key_reg[23:0], in_byte_reg};
                end
                hdr_pos_next = pos_inc;
                if (pos_inc >= hdr_total) begin
                    if (chk != wsdf_pkg::ST_OK) begin
                        emit             = 1'b1;
                        stopped_next     = 1'b1;
                        res.frame_opcode = cur_op_reg;
                        res.status       = chk;
                        res.halted       = 1'b1;
                    end else begin
                        if (!is_ctrl) begin
                            if (cur_op_reg != wsdf_pkg::OP_CONT) begin
                                msg_op_next     = cur_op_reg;
                                msg_active_next = 1'b1;
                            end
                            msg_size_next = sum_size;
                        end
                        idx_next     = 2'd0;
                        remain_next  = plen_eff;
                        hdr_pos_next = 4'd0;
                        if (plen_eff != 64'd0) begin
                            in_payload_next = 1'b1;
                        end else begin
                            // Empty frame gives one marker without a byte.
                            emit             = 1'b1;
                            res.frame_opcode = is_ctrl ? cur_op_reg : msg_op_next;
                            finish           = 1'b1;
                        end
                    end
                end
            end

            // Close out a frame that passed its checks.
            if (finish) begin
                res.frame_last = 1'b1;
                if (!is_ctrl) begin
                    res.message_last = fin_reg;
                    if (fin_reg) begin
                        msg_active_next = 1'b0;
                        msg_size_next   = '0;
                    end
                end else begin
                    res.message_last = 1'b1;
                    if (cur_op_reg == wsdf_pkg::OP_CLOSE) begin
                        stopped_next = 1'b1;
                        res.halted   = 1'b1;
                    end
                end
                in_payload_next = 1'b0;
                hdr_pos_next    = 4'd0;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_pos_reg    <= '0;
            fin_reg        <= 1'b0;
            cur_op_reg     <= '0;
            mask_flag_reg  <= 1'b0;
            short_len_reg  <= '0;
            pay_len_reg    <= '0;
            mask_key_reg   <= '0;
            remain_reg     <= '0;
            idx_reg        <= '0;
            in_payload_reg <= 1'b0;
            msg_active_reg <= 1'b0;
            msg_op_reg     <= '0;
            msg_size_reg   <= '0;
            stopped_reg    <= 1'b0;
        end else begin
            hdr_pos_reg    <= hdr_pos_next;
            fin_reg        <= fin_next;
            cur_op_reg     <= cur_op_next;
            mask_flag_reg  <= mask_flag_next;
            short_len_reg  <= short_len_next;
            pay_len_reg    <= pay_len_next;
            mask_key_reg   <= mask_key_next;
            remain_reg     <= remain_next;
            idx_reg        <= idx_next;
            in_payload_reg <= in_payload_next;
            msg_active_reg <= msg_active_next;
            msg_op_reg     <= msg_op_next;
            msg_size_reg   <= msg_size_next;
            stopped_reg    <= stopped_next;
        end
    end

    // Result register.
    wsdf_pkg::result_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.halted, out_reg.status, out_reg.message_last,
                       out_reg.data_byte};
    assign m_tuser  = {out_reg.frame_opcode, out_reg.byte_valid};
    assign m_tlast  = out_reg.frame_last;

`include "websocket_frame_deframer_top_assert.svh"

    `WSDF_ASSERT_SAME(a_error_halts, aclk, aresetn,
        out_valid_reg && out_reg.status != wsdf_pkg::ST_OK, out_reg.halted,
        "error result without halted")
    `WSDF_ASSERT_NEXT(a_stop_sticks, aclk, aresetn, stopped_reg, stopped_reg,
        "parser left the stopped state without reset")
    `WSDF_ASSERT_SAME(a_payload_count, aclk, aresetn, in_payload_reg, remain_reg != 64'd0,
        "payload phase with nothing left to receive")
    `WSDF_ASSERT_SAME(a_empty_zero, aclk, aresetn,
        out_valid_reg && !out_reg.byte_valid, out_reg.data_byte == 8'd0,
        "marker result carries a nonzero data byte")

endmodule

// ----- tb/websocket_frame_deframer_top_tb.sv -----
module websocket_frame_deframer_top_tb;

    // Opcodes and register index used only here.
    localparam logic [3:0] OP_TEXT          = 4'd1;
    localparam logic [3:0] OP_BINARY        = 4'd2;
    localparam logic [3:0] OP_LAST_DATA     = 4'd7;
    localparam logic [3:0] OP_PING          = 4'd9;
    localparam logic [3:0] OP_PONG          = 4'd10;
    localparam logic [3:0] OP_FIRST_UNK_CTL = 4'd11;
    localparam logic [3:0] OP_TOP           = 4'd15;
    localparam logic [1:0] CFG_UNUSED       = 2'd3;

    // Length encodings for generated headers.
    localparam int ENC_AUTO = 0;
    localparam int ENC_16   = 1;
    localparam int ENC_64   = 2;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;

    websocket_frame_deframer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Byte stream still to be sent and results still to arrive.
    logic [7:0]        rx_stream[$];
    wsdf_pkg::result_t due_results[$];
    int                error_count = 0;

    // Register mirror.
    logic        cfg_client = 1'b0;
    logic        cfg_limit = 1'b0;
    logic [31:0] cfg_max = 32'd0;

    // Parser state of the predictor.
    int unsigned hdr_pos = 0;
    logic        fin_bit = 1'b0;
    logic [3:0]  cur_op = 4'd0;
    logic        masked = 1'b0;
    logic [6:0]  len7 = 7'd0;
    logic [63:0] frame_len = 64'd0;
    logic [31:0] key = 32'd0;
    logic [63:0] pay_idx = 64'd0;
    logic        in_body = 1'b0;
    logic        msg_open = 1'b0;
    logic [3:0]  msg_op = 4'd0;
    logic [63:0] msg_bytes = 64'd0;
    logic        dead = 1'b0;

    // Message state as the stimulus generator plans it.
    logic        plan_open = 1'b0;
    logic [63:0] plan_bytes = 64'd0;

    // Handshake pacing.
    int   send_gap = 0;
    int   recv_hold = 0;
    logic send_quiet = 1'b0;
    logic recv_quiet = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Number of extended length bytes that the 7-bit length calls for.
    function automatic int ext_len_bytes();
        if (len7 == wsdf_pkg::LEN_EXT16) return 2;
        if (len7 == wsdf_pkg::LEN_EXT64) return 8;
        return 0;
    endfunction

    // Header checks, in the order the block applies them.
    function automatic wsdf_pkg::status_t header_verdict();
        logic [63:0] base;
        if (cfg_client ? masked : !masked) return wsdf_pkg::ST_MASK;
        if (cfg_limit && frame_len > {32'd0, cfg_max}) return wsdf_pkg::ST_FRAME_BIG;
        if (cur_op >= wsdf_pkg::OP_CLOSE) begin
            if (!fin_bit || frame_len > wsdf_pkg::CTRL_MAX_LEN) return wsdf_pkg::ST_BAD_CTRL;
            if (cur_op > wsdf_pkg::OP_LAST_CTRL) return wsdf_pkg::ST_UNK_CTRL;
            return wsdf_pkg::ST_OK;
        end
        if (cur_op == wsdf_pkg::OP_CONT && !msg_open) return wsdf_pkg::ST_UNEXP_CONT;
        if (cur_op != wsdf_pkg::OP_CONT && msg_open) return wsdf_pkg::ST_EXP_CONT;
        if (cur_op >= wsdf_pkg::OP_FIRST_BAD) return wsdf_pkg::ST_UNK_DATA;
        if (cfg_limit) begin
            base = (cur_op == wsdf_pkg::OP_CONT) ? msg_bytes : 64'd0;
            if (base + frame_len > {32'd0, cfg_max}) return wsdf_pkg::ST_MSG_BIG;
        end
        return wsdf_pkg::ST_OK;
    endfunction

    // Ends a frame that passed its checks and returns the message-last mark.
    function automatic logic close_frame();
        logic ml;
        ml = 1'b1;
        if (cur_op < wsdf_pkg::OP_CLOSE) begin
            ml = fin_bit;
            if (fin_bit) begin
                msg_open = 1'b0;
                msg_bytes = 64'd0;
            end
        end else if (cur_op == wsdf_pkg::OP_CLOSE) begin
            dead = 1'b1;
        end
        in_body = 1'b0;
        hdr_pos = 0;
        return ml;
    endfunction

    // Advances the parser by one received byte and queues the result it causes.
    function automatic void deframe_byte(input logic [7:0] b);
        wsdf_pkg::result_t r;
        logic [7:0]        kb;
        logic              at_end;
        int unsigned       total;
        wsdf_pkg::status_t st;
        if (dead) return;
        r = '0;

        // Payload byte: unmask and tag it.
        if (in_body) begin
            kb = 8'(key >> (24 - 8 * pay_idx[1:0]));
            at_end = (pay_idx + 64'd1 == frame_len);
            pay_idx = pay_idx + 64'd1;
            r.data_byte = b ^ kb;
            r.byte_valid = 1'b1;
            r.frame_opcode = (cur_op >= wsdf_pkg::OP_CLOSE) ? cur_op : msg_op;
            if (at_end) begin
                r.frame_last = 1'b1;
                r.halted = (cur_op == wsdf_pkg::OP_CLOSE);
                r.message_last = close_frame();
            end
            due_results.push_back(r);
            return;
        end

        // First header byte: FIN and opcode.
        if (hdr_pos == 0) begin
            fin_bit = b[7];
            cur_op = b[3:0];
            key = 32'd0;
            frame_len = 64'd0;
            hdr_pos = 1;
            return;
        end

        // Remaining header bytes: length, extended length, mask key.
        if (hdr_pos == 1) begin
            masked = b[7];
            len7 = b[6:0];
            frame_len = (ext_len_bytes() != 0) ? 64'd0 : {57'd0, len7};
        end else if (hdr_pos < 2 + ext_len_bytes()) begin
            frame_len = {frame_len[55:0], b};
        end else begin
            key = {key[23:0], b};
        end
        hdr_pos++;
        total = 2 + ext_len_bytes() + (masked ? 4 : 0);
        if (hdr_pos < total) return;

        // Header complete.
        st = header_verdict();
        if (st != wsdf_pkg::ST_OK) begin
            dead = 1'b1;
            r.frame_opcode = cur_op;
            r.status = st;
            r.halted = 1'b1;
            due_results.push_back(r);
            return;
        end
        if (cur_op < wsdf_pkg::OP_CLOSE) begin
            if (cur_op != wsdf_pkg::OP_CONT) begin
                msg_op = cur_op;
                msg_open = 1'b1;
                msg_bytes = 64'd0;
            end
            msg_bytes = msg_bytes + frame_len;
        end
        pay_idx = 64'd0;
        if (frame_len != 64'd0) begin
            in_body = 1'b1;
            return;
        end

        // An empty frame gives one marker without a byte.
        r.frame_opcode = (cur_op >= wsdf_pkg::OP_CLOSE) ? cur_op : msg_op;
        r.frame_last = 1'b1;
        r.halted = (cur_op == wsdf_pkg::OP_CLOSE);
        r.message_last = close_frame();
        due_results.push_back(r);
    endfunction

    function automatic void compare_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    // Compares the result beat on the bus with the oldest expectation.
    function automatic void check_beat();
        wsdf_pkg::result_t want;
        if (due_results.size() == 0) begin
            $display("%0t: unexpected result beat: expected nothing, got %h %h %b",
                     $time, m_tdata, m_tuser, m_tlast);
            error_count++;
            return;
        end
        want = due_results.pop_front();
        compare_field("data_byte", int'(want.data_byte), int'(m_tdata[7:0]));
        compare_field("byte_valid", int'(want.byte_valid), int'(m_tuser[0]));
        compare_field("frame_opcode", int'(want.frame_opcode), int'(m_tuser[4:1]));
        compare_field("frame_last", int'(want.frame_last), int'(m_tlast));
        compare_field("message_last", int'(want.message_last), int'(m_tdata[8]));
        compare_field("status", int'(want.status), int'(m_tdata[12:9]));
        compare_field("halted", int'(want.halted), int'(m_tdata[13]));
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int idle_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Payload and key bytes, with the all-zero and all-one values favored.
    function automatic logic [7:0] pick_byte();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return 8'h00;
        if (p == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    // Payload length up to cap (and never beyond 300), mostly short.
    function automatic logic [63:0] pick_len(input logic [63:0] cap);
        int c;
        int p;
        c = (cap > 64'd300) ? 300 : int'(cap);
        p = $urandom_range(0, 99);
        if (c == 0 || p < 10) return 64'd0;
        if (p < 75) return 64'($urandom_range(1, (c < 16) ? c : 16));
        if (p < 95) return 64'($urandom_range(1, (c < 60) ? c : 60));
        if (p < 98) return 64'($urandom_range(1, c));
        return 64'(c);
    endfunction

    function automatic int pick_enc();
        int p;
        p = $urandom_range(0, 99);
        if (p < 80) return ENC_AUTO;
        if (p < 95) return ENC_16;
        return ENC_64;
    endfunction

    // Queues one frame: header, optional mask key and, if asked, the payload.
    task automatic send_frame(input logic fin, input logic [3:0] op, input logic mask_bit,
                              input logic [63:0] len, input int enc, input logic body);
        logic [63:0] i;
        int k;
        rx_stream.push_back({fin, 3'($urandom_range(0, 7)), op});
        if (len > 64'd65535) enc = ENC_64;
        else if (len > 64'd125 && enc == ENC_AUTO) enc = ENC_16;
        case (enc)
            ENC_16: begin
                rx_stream.push_back({mask_bit, wsdf_pkg::LEN_EXT16});
                rx_stream.push_back(len[15:8]);
                rx_stream.push_back(len[7:0]);
            end
            ENC_64: begin
                rx_stream.push_back({mask_bit, wsdf_pkg::LEN_EXT64});
                for (k = 7; k >= 0; k--) rx_stream.push_back(len[8 * k +: 8]);
            end
            default: begin
                rx_stream.push_back({mask_bit, len[6:0]});
            end
        endcase
        if (mask_bit) repeat (4) rx_stream.push_back(pick_byte());
        if (body) begin
            for (i = 64'd0; i < len; i++) rx_stream.push_back(pick_byte());
        end
    endtask

    // Well-formed traffic for the current register setting: fragmented and
    // whole messages with pings and pongs in between, kept within the limits.
    task automatic random_traffic(input int target);
        int          start_size;
        logic [63:0] room;
        logic [63:0] len;
        logic        fin;
        logic [3:0]  op;
        logic        ok_mask;
        start_size = rx_stream.size();
        ok_mask = !cfg_client;
        while (rx_stream.size() - start_size < target) begin
            room = cfg_limit ? {32'd0, cfg_max} : 64'd300;
            if ($urandom_range(0, 4) == 0) begin
                op = $urandom_range(0, 1) ? OP_PING : OP_PONG;
                len = pick_len((room > wsdf_pkg::CTRL_MAX_LEN) ? wsdf_pkg::CTRL_MAX_LEN : room);
                send_frame(1'b1, op, ok_mask, len, pick_enc(), 1'b1);
            end else if (!plan_open) begin
                fin = 1'($urandom_range(0, 1));
                op = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
                len = pick_len(room);
                send_frame(fin, op, ok_mask, len, pick_enc(), 1'b1);
                plan_open = !fin;
                plan_bytes = len;
            end else begin
                if (cfg_limit) room = {32'd0, cfg_max} - plan_bytes;
                fin = ($urandom_range(0, 2) == 0);
                len = pick_len(room);
                send_frame(fin, wsdf_pkg::OP_CONT, ok_mask, len, pick_enc(), 1'b1);
                plan_bytes = plan_bytes + len;
                if (fin) plan_open = 1'b0;
            end
        end
        // Leave no message open across a register change.
        if (plan_open) send_frame(1'b1, wsdf_pkg::OP_CONT, ok_mask, 64'd0, pick_enc(), 1'b1);
        plan_open = 1'b0;
        plan_bytes = 64'd0;
    endtask

    // Register write; the mirror follows at once since the block is idle.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            wsdf_pkg::CFG_CLIENT_SIDE: cfg_client = value[0];
            wsdf_pkg::CFG_LIMIT_ENABLE: cfg_limit = value[0];
            wsdf_pkg::CFG_MAX_MESSAGE: cfg_max = value;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // One closing event: a close frame or one of the header errors, then
    // bytes that the stopped block must drop.
    task automatic final_frames();
        wsdf_pkg::status_t finale;
        logic              ok_mask;
        logic [63:0]       big_len;
        int                len1;
        finale = wsdf_pkg::status_t'($urandom_range(wsdf_pkg::ST_OK, wsdf_pkg::ST_MSG_BIG));
        write_reg(wsdf_pkg::CFG_CLIENT_SIDE, {31'($urandom), 1'($urandom_range(0, 1))});
        write_reg(wsdf_pkg::CFG_LIMIT_ENABLE,
                  {31'($urandom), 1'(finale == wsdf_pkg::ST_FRAME_BIG ||
                                     finale == wsdf_pkg::ST_MSG_BIG)});
        case (finale)
            wsdf_pkg::ST_FRAME_BIG: begin
                case ($urandom_range(0, 2))
                    0: write_reg(wsdf_pkg::CFG_MAX_MESSAGE, 32'd0);
                    1: write_reg(wsdf_pkg::CFG_MAX_MESSAGE, $urandom_range(1, 200));
                    default: write_reg(wsdf_pkg::CFG_MAX_MESSAGE, 32'hFFFF_FFFF);
                endcase
            end
            wsdf_pkg::ST_MSG_BIG: write_reg(wsdf_pkg::CFG_MAX_MESSAGE, $urandom_range(1, 60));
            default: write_reg(wsdf_pkg::CFG_MAX_MESSAGE, $urandom);
        endcase
        end_writes();

        ok_mask = !cfg_client;
        case (finale)
            wsdf_pkg::ST_OK: begin
                send_frame(1'b1, wsdf_pkg::OP_CLOSE, ok_mask, pick_len(wsdf_pkg::CTRL_MAX_LEN),
                           pick_enc(), 1'b1);
            end
            wsdf_pkg::ST_MASK: begin
                send_frame(1'($urandom_range(0, 1)), 4'($urandom), !ok_mask, pick_len(64'd300),
                           pick_enc(), 1'b0);
            end
            wsdf_pkg::ST_FRAME_BIG: begin
                big_len = {32'd0, cfg_max} + 64'd1 + 64'($urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0) big_len[63] = 1'b1;
                send_frame(1'b1, OP_BINARY, ok_mask, big_len, pick_enc(), 1'b0);
            end
            wsdf_pkg::ST_BAD_CTRL: begin
                if ($urandom_range(0, 1))
                    send_frame(1'b0, 4'($urandom_range(wsdf_pkg::OP_CLOSE, OP_TOP)), ok_mask,
                               pick_len(wsdf_pkg::CTRL_MAX_LEN), pick_enc(), 1'b0);
                else
                    send_frame(1'b1, 4'($urandom_range(wsdf_pkg::OP_CLOSE, OP_TOP)), ok_mask,
                               64'($urandom_range(126, 400)), ENC_16, 1'b0);
            end
            wsdf_pkg::ST_UNEXP_CONT: begin
                send_frame(1'($urandom_range(0, 1)), wsdf_pkg::OP_CONT, ok_mask,
                           pick_len(64'd300), pick_enc(), 1'b0);
            end
            wsdf_pkg::ST_EXP_CONT: begin
                send_frame(1'b0, $urandom_range(0, 1) ? OP_TEXT : OP_BINARY, ok_mask,
                           pick_len(64'd40), pick_enc(), 1'b1);
                send_frame(1'($urandom_range(0, 1)), 4'($urandom_range(OP_TEXT, OP_LAST_DATA)),
                           ok_mask, pick_len(64'd40), pick_enc(), 1'b0);
            end
            wsdf_pkg::ST_UNK_CTRL: begin
                send_frame(1'b1, 4'($urandom_range(OP_FIRST_UNK_CTL, OP_TOP)), ok_mask,
                           pick_len(wsdf_pkg::CTRL_MAX_LEN), pick_enc(), 1'b0);
            end
            wsdf_pkg::ST_UNK_DATA: begin
                send_frame(1'($urandom_range(0, 1)),
                           4'($urandom_range(wsdf_pkg::OP_FIRST_BAD, OP_LAST_DATA)),
                           ok_mask, pick_len(64'd300), pick_enc(), 1'b0);
            end
            default: begin
                // The second fragment fits the frame limit but overflows the message.
                len1 = $urandom_range(1, cfg_max);
                send_frame(1'b0, $urandom_range(0, 1) ? OP_TEXT : OP_BINARY, ok_mask,
                           64'(len1), pick_enc(), 1'b1);
                send_frame(1'($urandom_range(0, 1)), wsdf_pkg::OP_CONT, ok_mask,
                           64'($urandom_range(cfg_max - len1 + 1, cfg_max)), pick_enc(), 1'b0);
            end
        endcase
        repeat (16) rx_stream.push_back(8'($urandom));
    endtask

    // Waits until every byte is sent and every result is in, then lets the
    // pipeline drain past any header bytes still in flight.
    task automatic settle();
        while (rx_stream.size() != 0 || s_tvalid || due_results.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Input driver: presents queued bytes, with random gaps between beats.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap != 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (rx_stream.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= rx_stream.pop_front();
                send_gap <= send_quiet ? 0 : idle_length();
            end else begin
                s_tvalid <= 1'b0;
            end
            if ($urandom_range(0, 255) == 0) send_quiet <= !send_quiet;
        end
    end

    // Monitor: predicts on each accepted byte, checks each accepted result
    // beat, and stalls the result side at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_hold <= 0;
        end else begin
            if (s_tvalid && s_tready) deframe_byte(s_tdata);
            if (m_tvalid && m_tready) check_beat();
            if (recv_hold != 0) begin
                m_tready <= 1'b0;
                recv_hold <= recv_hold - 1;
            end else if (!recv_quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                recv_hold <= idle_length();
            end else begin
                m_tready <= 1'b1;
            end
            if ($urandom_range(0, 255) == 0) recv_quiet <= !recv_quiet;
        end
    end

    // Stimulus sequence.
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset setting: masked frames required, no limits. An empty text
        // message, a fragmented binary message with a ping between its
        // fragments, and a final fragment with a 16-bit length.
        send_frame(1'b1, OP_TEXT, 1'b1, 64'd0, ENC_AUTO, 1'b1);
        send_frame(1'b0, OP_BINARY, 1'b1, 64'd1, ENC_AUTO, 1'b1);
        send_frame(1'b1, OP_PING, 1'b1, 64'd0, ENC_AUTO, 1'b1);
        send_frame(1'b1, wsdf_pkg::OP_CONT, 1'b1, 64'd1, ENC_16, 1'b1);
        settle();

        // Unmasked frames, no limits; a write to an unused index is ignored.
        write_reg(wsdf_pkg::CFG_CLIENT_SIDE, {31'($urandom), 1'b1});
        write_reg(CFG_UNUSED, $urandom);
        end_writes();
        random_traffic(320);
        settle();

        // Limits on with a zero maximum: only empty frames pass.
        write_reg(wsdf_pkg::CFG_CLIENT_SIDE, {31'($urandom), 1'b0});
        write_reg(wsdf_pkg::CFG_LIMIT_ENABLE, {31'($urandom), 1'b1});
        write_reg(wsdf_pkg::CFG_MAX_MESSAGE, 32'd0);
        end_writes();
        random_traffic(320);
        settle();

        // Largest maximum, unmasked frames.
        write_reg(wsdf_pkg::CFG_CLIENT_SIDE, {31'($urandom), 1'b1});
        write_reg(wsdf_pkg::CFG_MAX_MESSAGE, 32'hFFFF_FFFF);
        end_writes();
        random_traffic(320);
        settle();

        // Small maximum: messages can fill up to the limit exactly.
        write_reg(wsdf_pkg::CFG_CLIENT_SIDE, {31'($urandom), 1'b0});
        write_reg(wsdf_pkg::CFG_MAX_MESSAGE, $urandom_range(1, 64));
        end_writes();
        random_traffic(320);
        settle();

        // Limits off again with a random maximum left behind.
        write_reg(wsdf_pkg::CFG_CLIENT_SIDE, {31'($urandom), 1'($urandom_range(0, 1))});
        write_reg(wsdf_pkg::CFG_LIMIT_ENABLE, {31'($urandom), 1'b0});
        write_reg(wsdf_pkg::CFG_MAX_MESSAGE, $urandom);
        end_writes();
        random_traffic(320);
        settle();

        final_frames();
        settle();
        repeat (20) @(negedge aclk);

        if (error_count == 0 && due_results.size() == 0) begin
            $display("websocket_frame_deframer_top_tb: done, clean");
        end else begin
            $display("websocket_frame_deframer_top_tb: done, errors");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #30000000;
        $display("websocket_frame_deframer_top_tb: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/wsdf_pkg.sv
rtl/websocket_frame_deframer_top.sv
tb/websocket_frame_deframer_top_tb.sv
